// ===== src/ijs_pkg.sv =====
// Shared types, codes and reset constants for the irrigation job sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ijs_pkg;

    // Default sizing
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_VALVE_COUNT = 8;

    // Config register reset values
    localparam logic [7:0]  DEF_DEPRESS_SECS  = 8'd2;
    localparam logic [12:0] DEF_MAX_PRESSURE  = 13'd5000;
    localparam logic [11:0] DEF_MAX_RUN_SECS  = 12'd3600;

    // Config register indexes
    localparam logic [1:0] CFG_DEPRESS_SECS = 2'd0;
    localparam logic [1:0] CFG_MAX_PRESSURE = 2'd1;
    localparam logic [1:0] CFG_MAX_RUN_SECS = 2'd2;

    localparam int CFG_DATA_W = 13;

    // Command codes
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_ABORT  = 2'd1;
    localparam logic [1:0] FN_REPORT = 2'd2;
    localparam logic [1:0] FN_TICK   = 2'd3;

    // Pump reports that matter
    localparam logic [2:0] RPT_STABLE = 3'd3;
    localparam logic [2:0] RPT_ESTOP  = 3'd4;
    localparam logic [2:0] RPT_IDLE   = 3'd5;

    // Phase codes as shown on the result word
    localparam logic [1:0] OUT_PH_IDLE    = 2'd0;
    localparam logic [1:0] OUT_PH_RUN     = 2'd1;
    localparam logic [1:0] OUT_PH_FINISH  = 2'd2;
    localparam logic [1:0] OUT_PH_DEPRESS = 2'd3;

    // Command status
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Outcome of the last job
    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_SUCCESS = 2'd1;
    localparam logic [1:0] OUT_ABORT   = 2'd2;
    localparam logic [1:0] OUT_ESTOP   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  valve;
        logic [11:0] run_secs;
        logic [12:0] job_pressure;
        logic [2:0]  pump_report;
    } item_t;

    typedef struct packed {
        logic [3:0]  valve;
        logic [11:0] secs;
        logic [12:0] mbar;
    } job_t;

    typedef struct packed {
        logic [7:0]  depress_secs;
        logic [12:0] max_pressure;
        logic [11:0] max_run_secs;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [6:0]  jobs_queued;
        logic        valve_open;
        logic [3:0]  open_valve;
        logic [12:0] pressure_setpoint;
        logic [11:0] remaining_secs;
        logic [1:0]  last_outcome;
        logic [1:0]  cmd_status;
        logic        changed;
    } result_t;

endpackage

`default_nettype wire

// ===== src/ijs_in_stage.sv =====
// Input register: captures one word from the input channel.
// Depends on ijs_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module ijs_in_stage
    import ijs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t item_d,
    input  wire logic  take,
    output logic       valid_q,
    output item_t      item_q
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready = !valid_reg || take;
    assign valid_q  = valid_reg;
    assign item_q   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_d;
        end
    end

endmodule

`default_nettype wire

// ===== src/ijs_core.sv =====
// Sequencer state, job ring and the per-word update logic.
// Depends on ijs_pkg for item, job, config and result types.
`timescale 1ns / 1ps
`default_nettype none

module ijs_core
    import ijs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int VALVE_COUNT = DEF_VALVE_COUNT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RUN     = 2'd1,
        PH_FINISH  = 2'd2,
        PH_DEPRESS = 2'd3
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [11:0]      countdown_reg, countdown_next;
    logic [12:0]      setpoint_reg, setpoint_next;
    logic             vopen_reg, vopen_next;
    logic [3:0]       vidx_reg, vidx_next;
    logic [1:0]       outcome_reg, outcome_next;
    logic [1:0]       status;

    // Ring storage plus a prefetch of the entry after the head
    job_t             mem [QUEUE_DEPTH];
    job_t             pf_reg;
    logic             mem_we;
    logic [PTR_W-1:0] waddr, raddr;
    job_t             wdata;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] s);
        logic [PTR_W:0] r;
        begin
            r = (s >= (PTR_W+1)'(QUEUE_DEPTH)) ? s - (PTR_W+1)'(QUEUE_DEPTH) : s;
            return r[PTR_W-1:0];
        end
    endfunction

    assign waddr = wrap({1'b0, head_reg} + (PTR_W+1)'(count_reg));
    assign raddr = wrap({1'b0, step ? head_next : head_reg} + (PTR_W+1)'(1));
    assign wdata = '{valve: item.valve, secs: item.run_secs, mbar: item.job_pressure};

    always_comb
    begin
        logic range_bad;
        logic [CNT_W-1:0] count_dec;
        range_bad = ({1'b0, item.valve} >= 5'(VALVE_COUNT)) || (item.run_secs == 12'd0)
                    || (item.job_pressure == 13'd0)
                    || (item.job_pressure > cfg.max_pressure)
                    || (item.run_secs > cfg.max_run_secs);
        count_dec = (count_reg != '0) ? count_reg - CNT_W'(1) : '0;

        phase_next     = phase_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        countdown_next = countdown_reg;
        setpoint_next  = setpoint_reg;
        vopen_next     = vopen_reg;
        vidx_next      = vidx_reg;
        outcome_next   = outcome_reg;
        status         = ST_IGNORED;
        mem_we         = 1'b0;

        case (item.func)
            FN_ADD:
            begin
                if (range_bad)
                begin
                    status = ST_RANGE;
                end
                else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    status     = ST_DONE;
                    // first job in an empty ring starts straight from the word
                    if (count_reg == '0)
                    begin
                        vopen_next     = 1'b1;
                        vidx_next      = item.valve;
                        setpoint_next  = item.job_pressure;
                        countdown_next = item.run_secs;
                        phase_next     = PH_RUN;
                    end
                end
            end
            FN_ABORT:
            begin
                if (phase_reg == PH_RUN || (phase_reg == PH_FINISH && count_reg > CNT_W'(1)))
                begin
                    outcome_next   = OUT_ABORT;
                    setpoint_next  = 13'd0;
                    count_next     = '0;
                    phase_next     = PH_DEPRESS;
                    countdown_next = {4'd0, cfg.depress_secs};
                    status         = ST_DONE;
                end
            end
            FN_REPORT:
            begin
                if (item.pump_report == RPT_ESTOP)
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (count_reg != '0)
                        begin
                            outcome_next = OUT_ESTOP;
                        end
                        setpoint_next  = 13'd0;
                        count_next     = '0;
                        phase_next     = PH_DEPRESS;
                        countdown_next = {4'd0, cfg.depress_secs};
                        status         = ST_DONE;
                    end
                end
                else if (item.pump_report == RPT_IDLE && phase_reg == PH_FINISH)
                begin
                    count_next   = count_dec;
                    head_next    = wrap({1'b0, head_reg} + (PTR_W+1)'(1));
                    outcome_next = OUT_SUCCESS;
                    status       = ST_DONE;
                    if (count_dec != '0)
                    begin
                        vopen_next     = 1'b1;
                        vidx_next      = pf_reg.valve;
                        setpoint_next  = pf_reg.mbar;
                        countdown_next = pf_reg.secs;
                        phase_next     = PH_RUN;
                    end
                    else
                    begin
                        phase_next     = PH_DEPRESS;
                        countdown_next = {4'd0, cfg.depress_secs};
                    end
                end
            end
            FN_TICK:
            begin
                if (phase_reg == PH_RUN || phase_reg == PH_DEPRESS)
                begin
                    status = ST_DONE;
                    if (countdown_reg > 12'd1)
                    begin
                        countdown_next = countdown_reg - 12'd1;
                    end
                    else
                    begin
                        countdown_next = 12'd0;
                        if (phase_reg == PH_RUN)
                        begin
                            setpoint_next = 13'd0;
                            phase_next    = PH_FINISH;
                        end
                        else
                        begin
                            vopen_next = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                status = ST_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        result.phase             = 2'(phase_next);
        result.jobs_queued       = 7'(count_next);
        result.valve_open        = vopen_next;
        result.open_valve        = vopen_next ? vidx_next : 4'd0;
        result.pressure_setpoint = setpoint_next;
        result.remaining_secs    = (phase_next == PH_RUN) ? countdown_next : 12'd0;
        result.last_outcome      = outcome_next;
        result.cmd_status        = status;
        result.changed           = (phase_next != phase_reg) || (count_next != count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            countdown_reg <= 12'd0;
            setpoint_reg  <= 13'd0;
            vopen_reg     <= 1'b0;
            vidx_reg      <= 4'd0;
            outcome_reg   <= OUT_NONE;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            countdown_reg <= countdown_next;
            setpoint_reg  <= setpoint_next;
            vopen_reg     <= vopen_next;
            vidx_reg      <= vidx_next;
            outcome_reg   <= outcome_next;
        end
    end

    // Prefetch follows the slot after the head; bypass a write to that slot
    always_ff @(posedge clk)
    begin
        if (step && mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (step && mem_we && waddr == raddr)
        begin
            pf_reg <= wdata;
        end
        else
        begin
            pf_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ijs_out_stage.sv =====
// Result register with valid/ready toward the output channel.
// Depends on ijs_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module ijs_out_stage
    import ijs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result_d,
    input  wire logic    out_ready,
    output logic         out_valid,
    output logic         space,
    output result_t      result_q
);

    logic    valid_reg;
    result_t result_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result_q  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_d;
        end
    end

endmodule

`default_nettype wire

// ===== src/irrigation_job_sequencer.sv =====
// Irrigation job sequencer: top level, config registers and stage wiring.
// Path: input register -> update logic -> result register; a full result register stalls input.
// Throughput: one word per cycle while the output channel keeps taking results.
// The head job's successor is prefetched from the job ring so completion needs one read.
// Reset (async, active low): idle, empty queue, valve closed, config at defaults.
// Depends on ijs_pkg, ijs_in_stage, ijs_core, ijs_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module irrigation_job_sequencer
    import ijs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int VALVE_COUNT = DEF_VALVE_COUNT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            func,
    input  wire logic [3:0]            valve,
    input  wire logic [11:0]           run_secs,
    input  wire logic [12:0]           job_pressure,
    input  wire logic [2:0]            pump_report,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 phase,
    output logic [6:0]                 jobs_queued,
    output logic                       valve_open,
    output logic [3:0]                 open_valve,
    output logic [12:0]                pressure_setpoint,
    output logic [11:0]                remaining_secs,
    output logic [1:0]                 last_outcome,
    output logic [1:0]                 cmd_status,
    output logic                       changed
);

    cfg_t    cfg_reg;
    item_t   item_d, item_q;
    logic    item_valid, space, step;
    result_t result_d, result_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depress_secs <= DEF_DEPRESS_SECS;
            cfg_reg.max_pressure <= DEF_MAX_PRESSURE;
            cfg_reg.max_run_secs <= DEF_MAX_RUN_SECS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEPRESS_SECS: cfg_reg.depress_secs <= cfg_data[7:0];
                CFG_MAX_PRESSURE: cfg_reg.max_pressure <= cfg_data[12:0];
                CFG_MAX_RUN_SECS: cfg_reg.max_run_secs <= cfg_data[11:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign item_d = '{func: func, valve: valve, run_secs: run_secs,
                      job_pressure: job_pressure, pump_report: pump_report};
    assign step   = item_valid && space;

    ijs_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .item_d   (item_d),
        .take     (step),
        .valid_q  (item_valid),
        .item_q   (item_q)
    );

    ijs_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALVE_COUNT (VALVE_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_q),
        .cfg    (cfg_reg),
        .result (result_d)
    );

    ijs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .result_d  (result_d),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .space     (space),
        .result_q  (result_q)
    );

    assign phase             = result_q.phase;
    assign jobs_queued       = result_q.jobs_queued;
    assign valve_open        = result_q.valve_open;
    assign open_valve        = result_q.open_valve;
    assign pressure_setpoint = result_q.pressure_setpoint;
    assign remaining_secs    = result_q.remaining_secs;
    assign last_outcome      = result_q.last_outcome;
    assign cmd_status        = result_q.cmd_status;
    assign changed           = result_q.changed;

endmodule

`default_nettype wire

// ===== src/ijs_checker.sv =====
// Port-level checks for the irrigation job sequencer, bound to the top level.
// Depends on ijs_pkg for phase codes.
`timescale 1ns / 1ps
`default_nettype none

module ijs_checker
    import ijs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  phase,
    input wire logic [6:0]  jobs_queued,
    input wire logic        valve_open,
    input wire logic [3:0]  open_valve,
    input wire logic [12:0] pressure_setpoint,
    input wire logic [11:0] remaining_secs,
    input wire logic [1:0]  last_outcome,
    input wire logic [1:0]  cmd_status,
    input wire logic        changed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(jobs_queued)
            && $stable(pressure_setpoint) && $stable(remaining_secs)
            && $stable(last_outcome) && $stable(cmd_status) && $stable(changed))
        else $error("result word changed while stalled");

    a_closed_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valve_open |-> open_valve == 4'd0)
        else $error("valve index shown with no valve open");

    a_remaining_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase != OUT_PH_RUN |-> remaining_secs == 12'd0)
        else $error("remaining time outside running phase");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == OUT_PH_IDLE |-> jobs_queued == 7'd0 && !valve_open
            && pressure_setpoint == 13'd0)
        else $error("idle phase with jobs, open valve or pressure");

endmodule

bind irrigation_job_sequencer ijs_checker u_ijs_checker (.*);

`default_nettype wire
